>>> hdl/tmp_pkg.sv
// Shared types, constants and helpers for the trapezoidal motion profile generator.
package tmp_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [31:0] TICK      = 32'(64'd1 << FRAC_BITS);

  localparam logic [1:0] CFG_ACCEL  = 2'd0;
  localparam logic [1:0] CFG_DECEL  = 2'd1;
  localparam logic [1:0] CFG_SPEED  = 2'd2;
  localparam logic [1:0] CFG_ORIGIN = 2'd3;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] target;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               done_res;
  } out_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [33:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef enum logic [1:0] {
    PH_ACC,
    PH_CRU,
    PH_DEC
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE, S_BEG, S_DTA, S_DTD, S_MTH, S_CTH, S_MDA, S_MC0, S_MC1, S_MCB,
    S_DTR, S_SQ, S_DPA, S_DPC, S_DFU, S_CME, S_PROF, S_H0, S_H1, S_H2, S_H3,
    S_MPK, S_APK, S_CLP, S_FIN
  } state_e;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

>>> hdl/trapezoidal_motion_profile.sv
// Top level: sequencer and profile state of the trapezoidal motion profile generator.
// A tick beat uses up to two half-square passes and one cruise pass of the shared
// multiplier. A begin beat for a zero-length move starts no divider run; otherwise it
// uses up to five divider runs plus one square root. One beat is in work at a time.
// Reset clears the sequencer state, the profile boundaries, elapsed time and travel,
// so the block reports not done, and loads the rate registers with one in fixed point
// and the origin with zero.
module trapezoidal_motion_profile import tmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [31:0] accel_q, decel_q, speed_q, origin_q;
  logic        neg_q, neg_d, done_q, done_d, rsel_q, rsel_d, ov_q, ov_d;
  logic [31:0] ae_q, ae_d, ce_q, ce_d, me_q, me_d, pk_q, pk_d, el_q, el_d;
  logic [31:0] md_q, md_d, ta_q, ta_d, td_q, td_d, trav_q, trav_d;
  logic [31:0] tgt_q, tgt_d, dt_q, dt_d, hi_q, hi_d;
  logic [63:0] s_q, s_d, lo_q, lo_d;
  out_t        out_q, out_d;

  logic [31:0] a_nz, c_nz, v_nz, rate_w, dmag, half_w, full_w, cruise_w;
  logic [32:0] dpos, sum_tt;
  logic [64:0] thr_sum;
  logic [47:0] thr_w;
  logic [95:0] prod96;
  logic [63:0] hs_w, m_w, quot_w;
  logic [31:0] root_w, p_w, q_sat;
  logic        accept_w, tri_w, div_done, sqrt_done;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  div_req_t    div_req;
  sqrt_req_t   sqrt_req;

  tmp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (m_w)
  );

  tmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot_w)
  );

  tmp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (root_w)
  );

  assign a_nz     = (accel_q == 32'd0) ? 32'd1 : accel_q;
  assign c_nz     = (decel_q == 32'd0) ? 32'd1 : decel_q;
  assign v_nz     = (speed_q == 32'd0) ? 32'd1 : speed_q;
  assign rate_w   = rsel_q ? c_nz : a_nz;
  assign dpos     = {tgt_q[31], tgt_q} - {origin_q[31], origin_q};
  assign dmag     = dpos[32] ? 32'(33'd0 - dpos) : dpos[31:0];
  assign sum_tt   = 33'(ta_q) + 33'(td_q);
  assign thr_sum  = 65'(m_w) + (sum_tt[32] ? {1'b0, v_nz, 32'd0} : 65'd0);
  assign thr_w    = 48'(thr_sum >> (FRAC_BITS + 1));
  assign tri_w    = 48'(md_q) <= thr_w;
  assign prod96   = {m_w, 32'd0} + {32'd0, lo_q};
  assign hs_w     = 64'(prod96 >> (2 * FRAC_BITS + 1));
  assign q_sat    = sat32(quot_w);
  assign p_w      = (root_w > v_nz) ? v_nz : root_w;
  assign half_w   = sum_tt[32:1];
  assign full_w   = q_sat;
  assign cruise_w = (full_w > half_w) ? full_w - half_w : 32'd0;
  assign accept_w = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          state_d = (in_data_i.op == OP_BEGIN) ? S_BEG : S_PROF;
        end
      end
      S_BEG:  state_d = (dmag == 32'd0) ? S_PROF : S_DTA;
      S_DTA:  if (div_done) state_d = S_DTD;
      S_DTD:  if (div_done) state_d = S_MTH;
      S_MTH:  state_d = S_CTH;
      S_CTH:  state_d = tri_w ? S_MDA : S_DFU;
      S_MDA:  state_d = S_MC0;
      S_MC0:  state_d = S_MC1;
      S_MC1:  state_d = S_MCB;
      S_MCB:  state_d = S_DTR;
      S_DTR:  if (div_done) state_d = S_SQ;
      S_SQ:   if (sqrt_done) state_d = S_DPA;
      S_DPA:  if (div_done) state_d = S_DPC;
      S_DPC:  if (div_done) state_d = S_PROF;
      S_DFU:  if (div_done) state_d = S_CME;
      S_CME:  state_d = S_PROF;
      S_PROF: state_d = (el_q >= me_q) ? S_FIN : S_H0;
      S_H0:   state_d = S_H1;
      S_H1:   state_d = S_H2;
      S_H2:   state_d = S_H3;
      S_H3:   state_d = (phase_q == PH_CRU) ? S_MPK : S_CLP;
      S_MPK:  state_d = S_APK;
      S_APK:  state_d = (el_q > ce_q) ? S_H0 : S_CLP;
      S_CLP:  state_d = S_FIN;
      S_FIN:  if (!ov_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    neg_d = neg_q;  done_d = done_q; rsel_d = rsel_q; phase_d = phase_q;
    ae_d = ae_q;    ce_d = ce_q;     me_d = me_q;     pk_d = pk_q;
    el_d = el_q;    md_d = md_q;     ta_d = ta_q;     td_d = td_q;
    trav_d = trav_q; tgt_d = tgt_q;  dt_d = dt_q;     hi_d = hi_q;
    s_d = s_q;      lo_d = lo_q;     out_d = out_q;
    ov_d = ov_q && !out_ready_i;
    mul_en = 1'b0; mul_a = 32'd0; mul_b = 32'd0;
    div_req  = '0;
    sqrt_req = '0;
    case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          if (in_data_i.op == OP_BEGIN) begin
            tgt_d = in_data_i.target;
          end else begin
            el_d = sat32(64'(el_q) + 64'(TICK));
          end
        end
      end
      S_BEG: begin
        el_d   = 32'd0;
        trav_d = 32'd0;
        md_d   = dmag;
        neg_d  = dpos[32];
        if (dmag == 32'd0) begin
          neg_d = 1'b0;
          ae_d = 32'd0; ce_d = 32'd0; me_d = 32'd0; pk_d = 32'd0;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = 128'(v_nz) << FRAC_BITS;
          div_req.den   = 34'(a_nz);
        end
      end
      S_DTA: begin
        if (div_done) begin
          ta_d = q_sat;
          div_req.start = 1'b1;
          div_req.num   = 128'(v_nz) << FRAC_BITS;
          div_req.den   = 34'(c_nz);
        end
      end
      S_DTD: if (div_done) td_d = q_sat;
      S_MTH: begin
        mul_en = 1'b1; mul_a = sum_tt[31:0]; mul_b = v_nz;
      end
      S_CTH: begin
        if (!tri_w) begin
          div_req.start = 1'b1;
          div_req.num   = 128'(md_q) << FRAC_BITS;
          div_req.den   = 34'(v_nz);
        end
      end
      S_MDA: begin
        mul_en = 1'b1; mul_a = md_q; mul_b = a_nz;
      end
      S_MC0: begin
        hi_d = m_w[63:32];
        mul_en = 1'b1; mul_a = m_w[31:0]; mul_b = c_nz;
      end
      S_MC1: begin
        lo_d = m_w;
        mul_en = 1'b1; mul_a = hi_q; mul_b = c_nz;
      end
      S_MCB: begin
        div_req.start = 1'b1;
        div_req.num   = 128'(prod96) << 1;
        div_req.den   = 34'(a_nz) + 34'(c_nz);
      end
      S_DTR: begin
        if (div_done) begin
          sqrt_req.start = 1'b1;
          sqrt_req.x     = quot_w;
        end
      end
      S_SQ: begin
        if (sqrt_done) begin
          pk_d = p_w;
          div_req.start = 1'b1;
          div_req.num   = 128'(p_w) << FRAC_BITS;
          div_req.den   = 34'(a_nz);
        end
      end
      S_DPA: begin
        if (div_done) begin
          ae_d = q_sat;
          ce_d = q_sat;
          div_req.start = 1'b1;
          div_req.num   = 128'(pk_q) << FRAC_BITS;
          div_req.den   = 34'(c_nz);
        end
      end
      S_DPC: if (div_done) me_d = sat32(64'(ae_q) + 64'(q_sat));
      S_DFU: begin
        if (div_done) begin
          pk_d = v_nz;
          ae_d = ta_q;
          ce_d = sat32(64'(ta_q) + 64'(cruise_w));
        end
      end
      S_CME: me_d = sat32(64'(ce_q) + 64'(td_q));
      S_PROF: begin
        rsel_d = 1'b0;
        if (el_q >= me_q) begin
          done_d = 1'b1;
          trav_d = md_q;
        end else begin
          done_d = 1'b0;
          if (el_q <= ae_q) begin
            dt_d = el_q; phase_d = PH_ACC;
          end else begin
            dt_d = ae_q; phase_d = PH_CRU;
          end
        end
      end
      S_H0: begin
        mul_en = 1'b1; mul_a = dt_q; mul_b = dt_q;
      end
      S_H1: begin
        hi_d = m_w[63:32];
        mul_en = 1'b1; mul_a = m_w[31:0]; mul_b = rate_w;
      end
      S_H2: begin
        lo_d = m_w;
        mul_en = 1'b1; mul_a = hi_q; mul_b = rate_w;
      end
      S_H3: begin
        if (phase_q == PH_DEC) begin
          s_d = (s_q > hs_w) ? s_q - hs_w : 64'd0;
        end else begin
          s_d = hs_w;
        end
      end
      S_MPK: begin
        mul_en = 1'b1; mul_a = pk_q; mul_b = el_q - ae_q;
      end
      S_APK: begin
        s_d = s_q + (m_w >> FRAC_BITS);
        if (el_q > ce_q) begin
          dt_d = el_q - ce_q; rsel_d = 1'b1; phase_d = PH_DEC;
        end
      end
      S_CLP: trav_d = (s_q > 64'(md_q)) ? md_q : s_q[31:0];
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          out_d.position = neg_q ? origin_q - trav_q : origin_q + trav_q;
          out_d.done_res = done_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_ACC;
      accel_q  <= TICK;
      decel_q  <= TICK;
      speed_q  <= TICK;
      origin_q <= 32'd0;
      neg_q    <= 1'b0;
      done_q   <= 1'b0;
      rsel_q   <= 1'b0;
      ov_q     <= 1'b0;
      ae_q     <= 32'd0;
      ce_q     <= 32'd0;
      me_q     <= 32'd0;
      pk_q     <= 32'd0;
      el_q     <= 32'd0;
      md_q     <= 32'd0;
      trav_q   <= 32'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      done_q  <= done_d;
      rsel_q  <= rsel_d;
      ov_q    <= ov_d;
      ae_q    <= ae_d;
      ce_q    <= ce_d;
      me_q    <= me_d;
      pk_q    <= pk_d;
      el_q    <= el_d;
      md_q    <= md_d;
      trav_q  <= trav_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL:  accel_q  <= cfg_data_i;
          CFG_DECEL:  decel_q  <= cfg_data_i;
          CFG_SPEED:  speed_q  <= cfg_data_i;
          CFG_ORIGIN: origin_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q  <= ta_d;
    td_q  <= td_d;
    tgt_q <= tgt_d;
    dt_q  <= dt_d;
    hi_q  <= hi_d;
    s_q   <= s_d;
    lo_q  <= lo_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/tmp_mul.sv
// Registered 32 by 32 bit unsigned multiplier shared by the sequencer.
module tmp_mul import tmp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> hdl/tmp_div.sv
// Restoring radix-2 divider with a 128 bit dividend and a saturated 64 bit quotient.
module tmp_div import tmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d, den_q, den_d;
  logic [63:0] lo_q, lo_d, quot_q, quot_d;
  logic [34:0] trial;

  assign trial = {rem_q, lo_q[63]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    if (req_i.start) begin
      den_d = req_i.den;
      if (req_i.num[127:64] >= 64'(req_i.den)) begin
        quot_d = 64'hFFFF_FFFF_FFFF_FFFF;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = req_i.num[97:64];
        lo_d   = req_i.num[63:0];
        quot_d = 64'd0;
        cnt_d  = 6'd0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 34'(trial - {1'b0, den_q});
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = trial[33:0];
        quot_d = {quot_q[62:0], 1'b0};
      end
      lo_d  = {lo_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> hdl/tmp_sqrt.sv
// Bit-pair iterative integer square root of a 64 bit value.
module tmp_sqrt import tmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqrt_req_t   req_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d, res_q, res_d, bit_q, bit_d, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      x_d    = req_i.x;
      res_d  = 64'd0;
      bit_d  = 64'd1 << 62;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d   = x_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

>>> hdl/tmp_checker.sv
// Port-level checker for the trapezoidal motion profile generator, with its bind.
module tmp_checker import tmp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output beat dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input still ready right after a beat was taken.");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared without a preceding busy cycle.");

endmodule

bind trapezoidal_motion_profile tmp_checker u_tmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_trapezoidal_motion_profile.sv
// Self-checking testbench for the trapezoidal motion profile generator.
module tb_trapezoidal_motion_profile;
  import tmp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_ACCEL;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;

  trapezoidal_motion_profile dut (.*);

  in_t  pend_q[$];
  out_t expected_q[$];
  int   send_idle = 0;
  int   recv_stall = 0;
  int   errors = 0;

  logic [31:0] sh_accel, sh_decel, sh_speed, sh_origin;
  logic        mv_neg;
  logic [31:0] mv_acc_end, mv_cru_end, mv_end, mv_peak, mv_elapsed, mv_trav, mv_dist;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb_trapezoidal_motion_profile: done, errors");
    $finish;
  end

  function automatic logic [63:0] lift(input logic [31:0] r);
    return (r == 32'd0) ? 64'd1 : {32'd0, r};
  endfunction

  function automatic logic [63:0] clamp32(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den);
    return clamp32((num << FRAC_BITS) / den);
  endfunction

  function automatic logic [63:0] ramp_dist(input logic [63:0] rate, input logic [63:0] dt);
    logic [127:0] p;
    p = {64'd0, dt * dt} * {64'd0, rate};
    p = p >> (2 * FRAC_BITS + 1);
    return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] distance_at(input logic [63:0] t);
    logic [63:0] s, sub, lin;
    if (t <= mv_acc_end) begin
      s = ramp_dist(lift(sh_accel), t);
    end else begin
      lin = ({32'd0, mv_peak} * (t - mv_acc_end)) >> FRAC_BITS;
      s = ramp_dist(lift(sh_accel), mv_acc_end);
      s = (s + lin < s) ? 64'hFFFF_FFFF_FFFF_FFFF : s + lin;
      if (t > mv_cru_end) begin
        sub = ramp_dist(lift(sh_decel), t - mv_cru_end);
        s = (s > sub) ? s - sub : 64'd0;
      end
    end
    return (s > mv_dist) ? {32'd0, mv_dist} : s;
  endfunction

  task automatic plan_move(input logic [31:0] target);
    logic signed [63:0] org, tgt;
    logic [63:0]  dd, a, c, v, ta, td, thr, p, full, half, cru, ce;
    logic [127:0] w;
    org = 64'(signed'(sh_origin));
    tgt = 64'(signed'(target));
    a = lift(sh_accel);
    c = lift(sh_decel);
    v = lift(sh_speed);
    mv_elapsed = 0;
    mv_trav = 0;
    mv_neg = tgt < org;
    dd = mv_neg ? 64'(org - tgt) : 64'(tgt - org);
    mv_dist = dd[31:0];
    if (dd == 0) begin
      mv_neg = 1'b0;
      mv_acc_end = 0;
      mv_cru_end = 0;
      mv_end = 0;
      mv_peak = 0;
    end else begin
      ta = fx_div(v, a);
      td = fx_div(v, c);
      w = ({64'd0, ta + td} * {64'd0, v}) >> (FRAC_BITS + 1);
      thr = (w[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0];
      if (dd <= thr) begin
        w = ({64'd0, dd * a} * {64'd0, c}) << 1;
        w = w / {64'd0, a + c};
        p = root64((w[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0]);
        if (p > v) p = v;
        mv_peak = p[31:0];
        ta = fx_div(p, a);
        mv_acc_end = ta[31:0];
        mv_cru_end = ta[31:0];
        ce = clamp32({32'd0, mv_cru_end} + fx_div(p, c));
        mv_end = ce[31:0];
      end else begin
        full = fx_div(dd, v);
        half = (ta + td) >> 1;
        cru = (full > half) ? full - half : 64'd0;
        mv_peak = v[31:0];
        mv_acc_end = ta[31:0];
        ce = clamp32(ta + cru);
        mv_cru_end = ce[31:0];
        ce = clamp32({32'd0, mv_cru_end} + td);
        mv_end = ce[31:0];
      end
    end
  endtask

  task automatic predict_position(input in_t item);
    out_t        r;
    logic [63:0] e, tr;
    if (item.op == OP_BEGIN) begin
      plan_move(item.target);
    end else begin
      e = clamp32({32'd0, mv_elapsed} + {32'd0, TICK});
      mv_elapsed = e[31:0];
    end
    r.done_res = mv_elapsed >= mv_end;
    tr = r.done_res ? {32'd0, mv_dist} : distance_at({32'd0, mv_elapsed});
    mv_trav = tr[31:0];
    r.position = mv_neg ? sh_origin - mv_trav : sh_origin + mv_trav;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_position(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data_i <= pend_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat pos=%h done=%b", $time,
                   out_data_o.position, out_data_o.done_res);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_o.position !== want.position) begin
            $display("%0t: position expected %h actual %h", $time,
                     want.position, out_data_o.position);
            errors++;
          end
          if (out_data_o.done_res !== want.done_res) begin
            $display("%0t: done_res expected %b actual %b", $time,
                     want.done_res, out_data_o.done_res);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_item(input logic op, input logic [31:0] target);
    in_t it;
    it.op = op;
    it.target = target;
    pend_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pend_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ACCEL:  sh_accel = val;
      CFG_DECEL:  sh_decel = val;
      CFG_SPEED:  sh_speed = val;
      default:    sh_origin = val;
    endcase
  endtask

  task automatic cfg_all(input logic [31:0] a, input logic [31:0] c,
                         input logic [31:0] v, input logic [31:0] o);
    cfg_write(CFG_ACCEL, a);
    cfg_write(CFG_DECEL, c);
    cfg_write(CFG_SPEED, v);
    cfg_write(CFG_ORIGIN, o);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int n, lim, ticks, mode;
    logic [31:0] off;
    sh_accel = TICK;
    sh_decel = TICK;
    sh_speed = TICK;
    sh_origin = 0;
    mv_neg = 0;
    {mv_acc_end, mv_cru_end, mv_end, mv_peak, mv_elapsed, mv_trav, mv_dist} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(OP_TICK, 32'h1234_5678);
    push_item(OP_BEGIN, 32'd0);
    push_item(OP_BEGIN, 32'h0002_8000);
    repeat (6) push_item(OP_TICK, 32'hFFFF_FFFF);
    push_item(OP_BEGIN, 32'hFFF0_0000);
    repeat (4) push_item(OP_TICK, 32'd0);
    push_item(OP_BEGIN, 32'h7FFF_FFFF);
    push_item(OP_TICK, 32'd0);
    push_item(OP_BEGIN, 32'h8000_0000);
    push_item(OP_TICK, 32'd0);
    wait_drained();
    cfg_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    push_item(OP_TICK, 32'd0);
    push_item(OP_BEGIN, 32'h7FFF_FFFF);
    push_item(OP_TICK, 32'd0);
    push_item(OP_BEGIN, 32'h8000_0000);
    push_item(OP_TICK, 32'd0);
    wait_drained();
    cfg_all(32'hFFFF_FFFF, 32'd1, 32'd1, 32'h7FFF_FFFF);
    push_item(OP_BEGIN, 32'h7FFF_0000);
    push_item(OP_TICK, 32'd0);
    push_item(OP_BEGIN, 32'h8000_0000);
    push_item(OP_TICK, 32'd0);
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      mode = ph % 4;
      send_idle = (mode == 1) ? 47 : (mode == 3) ? 31 : 0;
      recv_stall = (mode == 2) ? 47 : (mode == 3) ? 31 : 0;
      if (ph % 5 == 4) begin
        cfg_all($urandom_range(1) ? 32'hFFFF_FFFF : 32'd1, $urandom(),
                $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1, $urandom());
      end else begin
        cfg_all($urandom_range(32'h800, 32'h40000), $urandom_range(32'h800, 32'h40000),
                $urandom_range(32'h4000, 32'h80000), $urandom());
      end
      n = 0;
      push_item(OP_TICK, $urandom());
      while (n < 115) begin
        if ($urandom_range(9) == 0) begin
          push_item(OP_BEGIN, $urandom());
          ticks = $urandom_range(0, 3);
        end else begin
          lim = sh_speed * $urandom_range(1, 40);
          off = $urandom_range(0, lim);
          if ($urandom_range(1)) off = -off;
          push_item(OP_BEGIN, sh_origin + off);
          ticks = $urandom_range(0, 50);
        end
        repeat (ticks) push_item(OP_TICK, $urandom());
        n += ticks + 1;
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_trapezoidal_motion_profile: done, clean");
    end else begin
      $display("tb_trapezoidal_motion_profile: done, errors");
    end
    $finish;
  end
endmodule
